// File: design/eui_pkg.sv
`default_nettype none

package eui_pkg;

  localparam int unsigned OUI_DEPTH_DEF = 256;

  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    MODE_LOAD    = 2'd0,
    MODE_RESTART = 2'd1,
    MODE_NEXT    = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PREFIX_LEN    = 2'd0,
    REG_START_NETWORK = 2'd1,
    REG_OUI_COUNT     = 2'd2,
    REG_NONE          = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  localparam logic [23:0] OUI_UL_FLIP = 24'h020000;
  localparam logic [7:0]  EUI_FILL_HI = 8'hFF;
  localparam logic [7:0]  EUI_FILL_LO = 8'hFE;
  localparam logic [6:0]  PREFIX_MAX  = 7'd64;

endpackage : eui_pkg

`default_nettype wire

// File: design/eui64_address_scan_generator_core.sv
`default_nettype none

// Modified EUI-64 IPv6 scan target generator. A next-address command (mode 2)
// raises busy for one cycle while the OUI table read completes, and the result
// appears with out_valid for exactly one cycle on the cycle after that. Load,
// restart and unused commands keep busy low and give no beat. The table is a
// single-port RAM, so a new command is not accepted while a next request holds
// busy high. Results are not held: the receiver must take each beat in the
// cycle it is shown. Table entries hold nothing until loaded; configure only
// while busy is low.
module eui64_address_scan_generator_core
  import eui_pkg::*;
#(
  parameter int unsigned OUI_DEPTH = OUI_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,

  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [1:0]           in_mode,
  input  wire logic [7:0]           in_oui_index,
  input  wire logic [23:0]          in_oui_value,

  output logic                      out_valid,
  output logic      [63:0]          out_addr_network,
  output logic      [63:0]          out_addr_interface,
  output logic                      out_exhausted,

  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]          cfg_wdata
);

  localparam int unsigned AW = (OUI_DEPTH > 1) ? $clog2(OUI_DEPTH) : 1;
  localparam int unsigned PW = $clog2(OUI_DEPTH + 1);

  // configuration
  logic [6:0]  prefix_len_r;
  logic [63:0] start_network_r;
  logic [8:0]  oui_count_r;

  // scan state
  state_t      state_r, state_nxt;
  logic [63:0] network_r;
  logic [23:0] nic_r;
  logic [PW-1:0] ptr_r;
  logic [23:0] cur_oui_r;
  logic        first_r;
  logic        done_r;

  logic        accept;
  logic        ram_we;
  logic [AW-1:0] ram_addr;
  logic [23:0] ram_rdata;

  logic [31:0] eff_count;
  logic [PW-1:0] ptr_wrap;
  logic [PW-1:0] rd_ptr;
  logic        nic_wrap;
  logic        list_end;
  logic [6:0]  pl;
  logic [63:0] sub_mask;
  logic [63:0] net_plus;
  logic [63:0] net_inc;
  logic        sub_wrap;
  logic        step_sub;
  logic        done_now;

  assign busy   = (state_r == ST_EXEC);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_len_r    <= PREFIX_MAX;
      start_network_r <= '0;
      oui_count_r     <= 9'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PREFIX_LEN:    prefix_len_r    <= cfg_wdata[6:0];
        REG_START_NETWORK: start_network_r <= cfg_wdata;
        REG_OUI_COUNT:     oui_count_r     <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  // step decision, valid at accept and unchanged through the exec cycle
  always_comb begin
    if (oui_count_r == 9'd0) begin
      eff_count = 32'd1;
    end else if (32'(oui_count_r) > OUI_DEPTH) begin
      eff_count = 32'(OUI_DEPTH);
    end else begin
      eff_count = 32'(oui_count_r);
    end
    ptr_wrap = (32'(ptr_r) >= OUI_DEPTH) ? '0 : ptr_r;
    nic_wrap = (nic_r == 24'hFFFFFF);
    list_end = (32'(ptr_r) >= eff_count);
    rd_ptr   = (first_r || list_end) ? '0 : ptr_wrap;
    step_sub = !done_r && !first_r && nic_wrap && list_end;

    pl       = (prefix_len_r > PREFIX_MAX) ? PREFIX_MAX : prefix_len_r;
    sub_mask = (pl == PREFIX_MAX) ? 64'd0 : (~64'd0 >> pl);
    net_plus = (network_r + 64'd1) & sub_mask;
    net_inc  = (network_r & ~sub_mask) | net_plus;
    sub_wrap = (net_plus == 64'd0);
    done_now = done_r || (step_sub && sub_wrap);
  end

  assign ram_we   = accept && (in_mode == MODE_LOAD) && (32'(in_oui_index) < OUI_DEPTH);
  assign ram_addr = (accept && (in_mode == MODE_LOAD)) ? AW'(in_oui_index)
                                                       : rd_ptr[AW-1:0];

  eui_ram #(
    .WIDTH (24),
    .DEPTH (OUI_DEPTH)
  ) u_oui_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_oui_value),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept && (in_mode == MODE_NEXT)) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      network_r <= '0;
      nic_r     <= '0;
      ptr_r     <= '0;
      cur_oui_r <= '0;
      first_r   <= 1'b1;
      done_r    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= (state_r == ST_EXEC);
      if (accept && (in_mode == MODE_RESTART)) begin
        network_r <= start_network_r;
        nic_r     <= '0;
        ptr_r     <= '0;
        cur_oui_r <= '0;
        first_r   <= 1'b1;
        done_r    <= 1'b0;
      end
      if (state_r == ST_EXEC) begin
        if (!done_r) begin
          if (first_r) begin
            first_r   <= 1'b0;
            ptr_r     <= PW'(1);
            nic_r     <= '0;
            cur_oui_r <= ram_rdata;
          end else begin
            nic_r <= nic_r + 24'd1;
            if (nic_wrap) begin
              cur_oui_r <= ram_rdata;
              ptr_r     <= rd_ptr + PW'(1);
            end
            if (step_sub) begin
              network_r <= net_inc;
              if (sub_wrap) done_r <= 1'b1;
            end
          end
        end
      end
    end
  end

  // result beat, built in the exec cycle from the updated view of the state
  logic [63:0] res_net;
  logic [23:0] res_oui;
  logic [23:0] res_nic;

  always_comb begin
    res_net = step_sub ? net_inc : network_r;
    res_oui = (first_r || nic_wrap) ? ram_rdata : cur_oui_r;
    res_nic = first_r ? 24'd0 : (nic_r + 24'd1);
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EXEC) begin
      if (done_now) begin
        out_addr_network   <= '0;
        out_addr_interface <= '0;
        out_exhausted      <= 1'b1;
      end else begin
        out_addr_network   <= res_net;
        out_addr_interface <= {res_oui ^ OUI_UL_FLIP, EUI_FILL_HI, EUI_FILL_LO, res_nic};
        out_exhausted      <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_beat_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_EXEC))
    else $error("result beat without a preceding exec cycle");

  a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("exec lasted more than one cycle");

  a_exhausted_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_exhausted) |-> (out_addr_network == 64'd0 &&
                                       out_addr_interface == 64'd0))
    else $error("exhausted beat carries an address");

  a_done_not_first: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !first_r)
    else $error("scan marked done before first request");
`endif

endmodule : eui64_address_scan_generator_core

`default_nettype wire

// File: design/eui_ram.sv
`default_nettype none

module eui_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule : eui_ram

`default_nettype wire
